@@ sv/cau_pkg.sv @@
package cau_pkg;

   // operation codes
   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_NEG = 3'd4
   } op_type;

   // status codes
   typedef logic [1:0] status_type;
   localparam status_type STAT_OK   = 2'd0;
   localparam status_type STAT_SAT  = 2'd1;
   localparam status_type STAT_DIVZ = 2'd2;

   // control that travels with each item down the pipeline
   typedef struct packed {
      logic   valid;
      op_type op;
   } ctl_type;

endpackage

@@ sv/cau_if.sv @@
interface cau_req_if #(parameter int W = 16);
   logic                valid;
   logic                ready;
   logic [2:0]          op;
   logic signed [W-1:0] a_re;
   logic signed [W-1:0] a_im;
   logic signed [W-1:0] b_re;
   logic signed [W-1:0] b_im;

   modport source (output valid, op, a_re, a_im, b_re, b_im, input ready);
   modport sink   (input valid, op, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if #(parameter int W = 16);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] res_re;
   logic signed [W-1:0] res_im;
   logic [1:0]          status;

   modport source (output valid, res_re, res_im, status, input ready);
   modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

@@ sv/complex_arithmetic_unit.sv @@
// Complex arithmetic unit: add, subtract, multiply, divide and negate on signed
// fixed-point complex operands (COMP_WIDTH bits, FRAC_BITS fraction bits).
// Fully pipelined: one item is taken every cycle unless the output is held; its
// result passes the front stages, the divider, which resolves one quotient bit
// per stage, and the output register. A held result on the response side
// stalls the whole pipeline; nothing is lost or repeated.
// Results saturate; status reports saturation or division by zero.
module complex_arithmetic_unit #(
   parameter int COMP_WIDTH = 16,
   parameter int FRAC_BITS  = 12
) (
   input  logic     clock,
   input  logic     reset,
   cau_req_if.sink   req_ch,
   cau_rsp_if.source rsp_ch
);
   import cau_pkg::*;

   localparam int W  = COMP_WIDTH;
   localparam int NW = 2*W + FRAC_BITS;
   localparam int DW = 2*W;
   localparam int QD = W + 2;

   logic en;
   logic out_v_ff;

   // whole pipeline moves when the output slot is free or being taken
   assign en           = !out_v_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   ctl_type             ctl_in, f_ctl;
   logic signed [W-1:0] f_re, f_im;
   logic                f_sat, f_nre, f_nim, f_dz;
   logic [NW-1:0]       f_mre, f_mim;
   logic [DW-1:0]       f_den;

   assign ctl_in = '{valid: req_ch.valid, op: op_type'(req_ch.op)};

   cau_front #(.W(W), .F(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .ctl_in   (ctl_in),
      .a_re     (req_ch.a_re),
      .a_im     (req_ch.a_im),
      .b_re     (req_ch.b_re),
      .b_im     (req_ch.b_im),
      .ctl_out  (f_ctl),
      .res_re   (f_re),
      .res_im   (f_im),
      .res_sat  (f_sat),
      .neg_re   (f_nre),
      .neg_im   (f_nim),
      .mag_re   (f_mre),
      .mag_im   (f_mim),
      .den      (f_den),
      .den_zero (f_dz)
   );

   logic signed [W-1:0] q_re, q_im;
   logic                q_sat_re, q_sat_im;

   cau_div #(.W(W), .F(FRAC_BITS)) u_div_re (
      .clock (clock),
      .en    (en),
      .neg   (f_nre),
      .mag   (f_mre),
      .den   (f_den),
      .quo   (q_re),
      .sat   (q_sat_re)
   );

   cau_div #(.W(W), .F(FRAC_BITS)) u_div_im (
      .clock (clock),
      .en    (en),
      .neg   (f_nim),
      .mag   (f_mim),
      .den   (f_den),
      .quo   (q_im),
      .sat   (q_sat_im)
   );

   // delay line matching the divider depth
   ctl_type             dl_ctl_ff [QD];
   logic signed [W-1:0] dl_re_ff  [QD];
   logic signed [W-1:0] dl_im_ff  [QD];
   logic                dl_sat_ff [QD];
   logic                dl_dz_ff  [QD];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QD; i++) dl_ctl_ff[i] <= '0;
      end else if (en) begin
         dl_ctl_ff[0] <= f_ctl;
         for (int i = 1; i < QD; i++) dl_ctl_ff[i] <= dl_ctl_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dl_re_ff[0]  <= f_re;
         dl_im_ff[0]  <= f_im;
         dl_sat_ff[0] <= f_sat;
         dl_dz_ff[0]  <= f_dz;
         for (int i = 1; i < QD; i++) begin
            dl_re_ff[i]  <= dl_re_ff[i-1];
            dl_im_ff[i]  <= dl_im_ff[i-1];
            dl_sat_ff[i] <= dl_sat_ff[i-1];
            dl_dz_ff[i]  <= dl_dz_ff[i-1];
         end
      end
   end

   // result select
   logic signed [W-1:0] o_re_in, o_im_in, o_re_ff, o_im_ff;
   status_type          o_st_in, o_st_ff;

   always_comb begin
      if (dl_ctl_ff[QD-1].op == OP_DIV) begin
         if (dl_dz_ff[QD-1]) begin
            o_re_in = '0;
            o_im_in = '0;
            o_st_in = STAT_DIVZ;
         end else begin
            o_re_in = q_re;
            o_im_in = q_im;
            o_st_in = (q_sat_re || q_sat_im) ? STAT_SAT : STAT_OK;
         end
      end else begin
         o_re_in = dl_re_ff[QD-1];
         o_im_in = dl_im_ff[QD-1];
         o_st_in = dl_sat_ff[QD-1] ? STAT_SAT : STAT_OK;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= dl_ctl_ff[QD-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_re_ff <= o_re_in;
         o_im_ff <= o_im_in;
         o_st_ff <= o_st_in;
      end
   end

   assign rsp_ch.valid  = out_v_ff;
   assign rsp_ch.res_re = o_re_ff;
   assign rsp_ch.res_im = o_im_ff;
   assign rsp_ch.status = o_st_ff;

endmodule

@@ sv/cau_front.sv @@
module cau_front #(
   parameter int W = 16,
   parameter int F = 12,
   localparam int NW = 2*W + F,
   localparam int DW = 2*W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  cau_pkg::ctl_type    ctl_in,
   input  logic signed [W-1:0] a_re,
   input  logic signed [W-1:0] a_im,
   input  logic signed [W-1:0] b_re,
   input  logic signed [W-1:0] b_im,
   output cau_pkg::ctl_type    ctl_out,
   output logic signed [W-1:0] res_re,
   output logic signed [W-1:0] res_im,
   output logic                res_sat,
   output logic                neg_re,
   output logic                neg_im,
   output logic [NW-1:0]       mag_re,
   output logic [NW-1:0]       mag_im,
   output logic [DW-1:0]       den,
   output logic                den_zero
);
   import cau_pkg::*;

   ctl_type ctl1_ff, ctl2_ff, ctl3_ff;

   // stage 1: products and the simple operations
   logic signed [2*W-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_br_ff, p_bi_ff;
   logic signed [W:0]     s_re_in, s_im_in, s_re1_ff, s_im1_ff;

   always_comb begin
      case (ctl_in.op)
         OP_ADD: begin
            s_re_in = (W+1)'(a_re) + (W+1)'(b_re);
            s_im_in = (W+1)'(a_im) + (W+1)'(b_im);
         end
         OP_SUB: begin
            s_re_in = (W+1)'(a_re) - (W+1)'(b_re);
            s_im_in = (W+1)'(a_im) - (W+1)'(b_im);
         end
         OP_NEG: begin
            s_re_in = -(W+1)'(a_re);
            s_im_in = -(W+1)'(a_im);
         end
         default: begin
            s_re_in = '0;
            s_im_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_rr_ff  <= (2*W)'(a_re) * (2*W)'(b_re);
         p_ii_ff  <= (2*W)'(a_im) * (2*W)'(b_im);
         p_ri_ff  <= (2*W)'(a_re) * (2*W)'(b_im);
         p_ir_ff  <= (2*W)'(a_im) * (2*W)'(b_re);
         p_br_ff  <= (2*W)'(b_re) * (2*W)'(b_re);
         p_bi_ff  <= (2*W)'(b_im) * (2*W)'(b_im);
         s_re1_ff <= s_re_in;
         s_im1_ff <= s_im_in;
      end
   end

   // stage 2: sums of products
   logic signed [2*W:0] m_re_ff, m_im_ff, d_re_ff, d_im_ff;
   logic signed [W:0]   s_re2_ff, s_im2_ff;
   logic [DW-1:0]       den2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         m_re_ff  <= (2*W+1)'(p_rr_ff) - (2*W+1)'(p_ii_ff);
         m_im_ff  <= (2*W+1)'(p_ri_ff) + (2*W+1)'(p_ir_ff);
         d_re_ff  <= (2*W+1)'(p_rr_ff) + (2*W+1)'(p_ii_ff);
         d_im_ff  <= (2*W+1)'(p_ir_ff) - (2*W+1)'(p_ri_ff);
         den2_ff  <= $unsigned(p_br_ff) + $unsigned(p_bi_ff);
         s_re2_ff <= s_re1_ff;
         s_im2_ff <= s_im1_ff;
      end
   end

   // stage 3: product scaling, saturation, divider operand setup
   logic signed [2*W:0] sh_re, sh_im, ad_re, ad_im;
   logic signed [W-1:0] r_re_in, r_im_in, r_re_ff, r_im_ff;
   logic                sat_re, sat_im, sat_ff;
   logic                ng_re_ff, ng_im_ff, dz_ff;
   logic [NW-1:0]       mg_re_ff, mg_im_ff;
   logic [DW-1:0]       den3_ff;

   always_comb begin
      sh_re = m_re_ff >>> F;
      sh_im = m_im_ff >>> F;
      if (ctl2_ff.op == OP_MUL) begin
         sat_re  = !(&sh_re[2*W:W-1] || ~|sh_re[2*W:W-1]);
         sat_im  = !(&sh_im[2*W:W-1] || ~|sh_im[2*W:W-1]);
         r_re_in = sat_re ? {sh_re[2*W], {(W-1){~sh_re[2*W]}}} : sh_re[W-1:0];
         r_im_in = sat_im ? {sh_im[2*W], {(W-1){~sh_im[2*W]}}} : sh_im[W-1:0];
      end else begin
         sat_re  = s_re2_ff[W] != s_re2_ff[W-1];
         sat_im  = s_im2_ff[W] != s_im2_ff[W-1];
         r_re_in = sat_re ? {s_re2_ff[W], {(W-1){~s_re2_ff[W]}}} : s_re2_ff[W-1:0];
         r_im_in = sat_im ? {s_im2_ff[W], {(W-1){~s_im2_ff[W]}}} : s_im2_ff[W-1:0];
      end
      ad_re = d_re_ff[2*W] ? -d_re_ff : d_re_ff;
      ad_im = d_im_ff[2*W] ? -d_im_ff : d_im_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_re_ff  <= r_re_in;
         r_im_ff  <= r_im_in;
         sat_ff   <= sat_re || sat_im;
         ng_re_ff <= d_re_ff[2*W];
         ng_im_ff <= d_im_ff[2*W];
         mg_re_ff <= NW'(ad_re[2*W-1:0]) << F;
         mg_im_ff <= NW'(ad_im[2*W-1:0]) << F;
         den3_ff  <= den2_ff;
         dz_ff    <= den2_ff == '0;
      end
   end

   // control: valid bits and operation codes
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else if (en) begin
         ctl1_ff <= ctl_in;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
      end
   end

   assign ctl_out  = ctl3_ff;
   assign res_re   = r_re_ff;
   assign res_im   = r_im_ff;
   assign res_sat  = sat_ff;
   assign neg_re   = ng_re_ff;
   assign neg_im   = ng_im_ff;
   assign mag_re   = mg_re_ff;
   assign mag_im   = mg_im_ff;
   assign den      = den3_ff;
   assign den_zero = dz_ff;

endmodule

@@ sv/cau_div.sv @@
module cau_div #(
   parameter int W = 16,
   parameter int F = 12,
   localparam int NW = 2*W + F,
   localparam int DW = 2*W
) (
   input  logic                clock,
   input  logic                en,
   input  logic                neg,
   input  logic [NW-1:0]       mag,
   input  logic [DW-1:0]       den,
   output logic signed [W-1:0] quo,
   output logic                sat
);
   localparam int RW = NW + W;

   logic [RW-1:0] r_ff   [W+1];
   logic [DW-1:0] d_ff   [W+1];
   logic [W-1:0]  q_ff   [W+1];
   logic          n_ff   [W+1];
   logic          ovf_ff [W+1];

   // overflow check: quotient needs more than W bits
   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]   <= RW'(mag);
         d_ff[0]   <= den;
         q_ff[0]   <= '0;
         n_ff[0]   <= neg;
         ovf_ff[0] <= RW'(mag) >= (RW'(den) << W);
      end
   end

   // one restoring step per stage, most significant quotient bit first
   for (genvar k = 1; k <= W; k++) begin : g_step
      localparam int B = W - k;
      logic [RW-1:0] t;
      logic          take;

      always_comb begin
         t    = RW'(d_ff[k-1]) << B;
         take = r_ff[k-1] >= t;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k]   <= take ? r_ff[k-1] - t : r_ff[k-1];
            q_ff[k]   <= q_ff[k-1] | (W'(take) << B);
            d_ff[k]   <= d_ff[k-1];
            n_ff[k]   <= n_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   // sign and saturation
   logic [W-1:0] qv;
   logic         sat_in;
   logic [W-1:0] quo_in;
   logic [W-1:0] quo_ff;
   logic         sat_ff;

   always_comb begin
      qv = q_ff[W];
      if (n_ff[W]) begin
         sat_in = ovf_ff[W] || (qv[W-1] && |qv[W-2:0]);
         quo_in = sat_in ? {1'b1, {(W-1){1'b0}}} : -qv;
      end else begin
         sat_in = ovf_ff[W] || qv[W-1];
         quo_in = sat_in ? {1'b0, {(W-1){1'b1}}} : qv;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
         sat_ff <= sat_in;
      end
   end

   assign quo = $signed(quo_ff);
   assign sat = sat_ff;

endmodule
